/* rtl/odrxc_pkg.sv */
// Package for the object data rotate-xor checksum: payload types, constants and codes.
`default_nettype none

package odrxc_pkg;

  localparam int unsigned BlockBytes = 32;
  localparam int unsigned PosW       = $clog2(BlockBytes);
  localparam int unsigned RotAmt     = 11;
  localparam int unsigned HdrBytes   = 9;

  localparam logic [31:0] CkSeed = 32'hF369A75B;

  // Configuration register indexes.
  localparam logic [1:0] CfgFlags    = 2'd0;
  localparam logic [1:0] CfgName     = 2'd1;
  localparam logic [1:0] CfgExpected = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_data;
  } in_t;

  typedef struct packed {
    logic [31:0] checksum;
    logic        checksum_matches;
  } out_t;

  // Control from the sequencer to the lane and block store.
  typedef struct packed {
    logic            absorb;
    logic [7:0]      data;
    logic            clear;
    logic [PosW-1:0] idx;
  } store_ctl_t;

endpackage

`default_nettype wire

/* rtl/odrxc_fold.sv */
// Shared fold unit: XOR one byte into the running value, then rotate left.
`default_nettype none

module odrxc_fold (
  input  logic [31:0] acc_i,
  input  logic [7:0]  byte_i,
  output logic [31:0] acc_o
);
  import odrxc_pkg::*;

  logic [31:0] mixed;

  assign mixed = acc_i ^ {24'h000000, byte_i};
  assign acc_o = {mixed[31-RotAmt:0], mixed[31:32-RotAmt]};

endmodule

`default_nettype wire

/* rtl/odrxc_store.sv */
// Lane accumulators, current block bytes and block position for the checksum.
`default_nettype none

module odrxc_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  odrxc_pkg::store_ctl_t         ctl_i,
  output logic [odrxc_pkg::PosW-1:0]    pos_o,
  output logic [7:0]                    lane_byte_o,
  output logic [7:0]                    tail_byte_o
);
  import odrxc_pkg::*;

  // Lanes hold the XOR of every absorbed byte, the open block included.
  logic [7:0]      lane_q [BlockBytes];
  logic [7:0]      part_q [BlockBytes];
  logic [PosW-1:0] pos_q;
  logic [PosW-1:0] pos_d;

  assign pos_d = pos_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      for (int i = 0; i < BlockBytes; i++) begin
        lane_q[i] <= 8'h00;
      end
    end else if (ctl_i.clear) begin
      pos_q <= '0;
      for (int i = 0; i < BlockBytes; i++) begin
        lane_q[i] <= 8'h00;
      end
    end else if (ctl_i.absorb) begin
      pos_q         <= pos_d;
      lane_q[pos_q] <= lane_q[pos_q] ^ ctl_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.absorb) begin
      part_q[pos_q] <= ctl_i.data;
    end
  end

  // Bytes of the open block are taken back out so that a lane reflects
  // complete blocks only.
  always_comb begin
    lane_byte_o = lane_q[ctl_i.idx];
    if (ctl_i.idx < pos_q) begin
      lane_byte_o = lane_q[ctl_i.idx] ^ part_q[ctl_i.idx];
    end
  end

  assign tail_byte_o = part_q[ctl_i.idx];
  assign pos_o       = pos_q;

endmodule

`default_nettype wire

/* rtl/object_data_rotate_xor_checksum.sv */
// Top level: configuration registers, fold sequencer and result register.
// A data item without the end mark is absorbed as it is accepted; items may follow back to back while busy is low.
// The final item starts a fold run of 9 header steps, 32 lane steps and T tail steps
// (T = bytes past the last full block, 0 to 31) through the one fold unit, one step a cycle.
// The result strobe is registered from the last fold step and rises in the same cycle that busy falls.
// Reset clears configuration and state registers, lanes and position; the receiver cannot stall the result.
`default_nettype none

module object_data_rotate_xor_checksum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  odrxc_pkg::in_t    in_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [63:0]       cfg_data_i,
  output logic              result_valid_o,
  output odrxc_pkg::out_t   result_o
);
  import odrxc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_HDR  = 4'b0010,
    S_LANE = 4'b0100,
    S_TAIL = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [PosW-1:0] cnt_q, cnt_d;
  logic [31:0]     acc_q, acc_d;
  logic [7:0]      flags_q;
  logic [63:0]     name_q;
  logic [31:0]     expected_q;
  logic            res_valid_q, res_valid_d;
  out_t            res_q;

  store_ctl_t      ctl;
  logic [PosW-1:0] pos;
  logic [7:0]      lane_byte;
  logic [7:0]      tail_byte;
  logic [71:0]     hdr_bytes;
  logic [7:0]      fold_byte;
  logic [31:0]     fold_out;
  logic            accept;
  logic            finish;

  assign accept    = start && (state_q == S_IDLE);
  assign hdr_bytes = {name_q, flags_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q    <= 8'h00;
      name_q     <= 64'h0;
      expected_q <= 32'h0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFlags:    flags_q    <= cfg_data_i[7:0];
        CfgName:     name_q     <= cfg_data_i;
        CfgExpected: expected_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (state_q)
      S_HDR:   fold_byte = hdr_bytes[{cnt_q[3:0], 3'b000} +: 8];
      S_LANE:  fold_byte = lane_byte;
      S_TAIL:  fold_byte = tail_byte;
      default: fold_byte = 8'h00;
    endcase
  end

  odrxc_fold u_fold (
    .acc_i  (acc_q),
    .byte_i (fold_byte),
    .acc_o  (fold_out)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    finish      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && in_i.end_of_data) begin
          state_d = S_HDR;
          cnt_d   = '0;
          acc_d   = CkSeed;
        end
      end
      S_HDR: begin
        acc_d = fold_out;
        if (cnt_q == PosW'(HdrBytes - 1)) begin
          state_d = S_LANE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_LANE: begin
        acc_d = fold_out;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == PosW'(BlockBytes - 1)) begin
          if (pos == '0) begin
            finish  = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_TAIL;
          end
        end
      end
      S_TAIL: begin
        acc_d = fold_out;
        cnt_d = cnt_q + 1'b1;
        if (cnt_d == pos) begin
          finish  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign res_valid_d = finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (finish) begin
      res_q.checksum         <= fold_out;
      res_q.checksum_matches <= (fold_out == expected_q);
    end
  end

  assign ctl.absorb = accept && in_i.byte_valid;
  assign ctl.data   = in_i.data_byte;
  assign ctl.clear  = finish;
  assign ctl.idx    = cnt_q;

  odrxc_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .pos_o       (pos),
    .lane_byte_o (lane_byte),
    .tail_byte_o (tail_byte)
  );

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // The run ends exactly when the result is strobed.
  a_fell_busy_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("busy dropped without a result");

  a_result_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe lasted more than one cycle");

  a_final_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.end_of_data) |=> busy)
    else $error("final transfer did not start a fold run");

  a_hdr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HDR) |-> (cnt_q < PosW'(HdrBytes)))
    else $error("header step count out of range");

  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TAIL) |-> (pos != '0) && (cnt_q < pos))
    else $error("tail step beyond the open block");

endmodule

`default_nettype wire
